/* hdl/fcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared widths and defaults for the face centre and area block.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int CW   = 24;   // coordinate / centre width
    localparam int AW   = 53;   // area component width
    localparam int MW   = 53;   // multiplier operand width
    localparam int PW   = 2 * MW;
    localparam int RW   = 104;  // square root radicand width
    localparam int QW   = RW / 2;
    localparam int DNW  = 88;   // dividend width
    localparam int DDW  = 62;   // divisor width

    localparam int          MAX_VERT_DEF = 16;
    localparam logic [31:0] THR_RESET    = 32'd1;

endpackage

/* hdl/polygon_face_centre_and_area.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_face_centre_and_area
// Face centre and area vector of a polygon streamed in as 3D vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one vertex per transaction, the final
//   vertex of a face marked by i_last_vertex. Vertices load at one per cycle;
//   past MAX_VERTICES they are dropped and the face is flagged.
//   After the last vertex o_stall stays high while a sequencer computes the
//   result on a shared bit-serial multiplier, square root and divider:
//   three mean divisions, then twelve products and one root for each of the
//   n fan triangles (n stored vertices), then three centre divisions. A
//   three-vertex face needs only the mean divisions and six products.
//   Output channel (o_valid / i_stall): one result transaction per face. The
//   result is held in output registers until taken; the block takes the next
//   face only after that.
//   Config channel (i_cfg_valid / o_cfg_ready): writes small_area_threshold,
//   always ready.
//   Reset (synchronous, active low) empties the face and sets the threshold
//   to 1. The vertex store holds no reset value.
// ----------------------------------------------------------------------------
module polygon_face_centre_and_area #(
    parameter int MAX_VERTICES = fcc_pkg::MAX_VERT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [fcc_pkg::CW-1:0] i_vertex_x,
    input  logic signed [fcc_pkg::CW-1:0] i_vertex_y,
    input  logic signed [fcc_pkg::CW-1:0] i_vertex_z,
    input  logic                          i_last_vertex,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [fcc_pkg::CW-1:0] o_centre_x,
    output logic signed [fcc_pkg::CW-1:0] o_centre_y,
    output logic signed [fcc_pkg::CW-1:0] o_centre_z,
    output logic signed [fcc_pkg::AW-1:0] o_area_x,
    output logic signed [fcc_pkg::AW-1:0] o_area_y,
    output logic signed [fcc_pkg::AW-1:0] o_area_z,
    output logic [1:0]                    o_face_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [31:0]                   i_cfg_data
);
    import fcc_pkg::*;

    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int ADRW = $clog2(MAX_VERTICES);
    localparam int SW   = CW + CNTW;            // running coordinate sums
    localparam int NW   = 52;                   // triangle normal
    localparam int SNW  = NW + 6;               // summed normal
    localparam int SAW  = 58;                   // summed magnitude
    localparam int SACW = DNW;                  // weighted centroid sums

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_MDIV  = 5'd1;
    localparam logic [4:0] S_MWAIT = 5'd2;
    localparam logic [4:0] S_RDA   = 5'd3;
    localparam logic [4:0] S_RDB   = 5'd4;
    localparam logic [4:0] S_RDC   = 5'd5;
    localparam logic [4:0] S_RDD   = 5'd6;
    localparam logic [4:0] S_MUL   = 5'd7;
    localparam logic [4:0] S_MULW  = 5'd8;
    localparam logic [4:0] S_TFIN  = 5'd9;
    localparam logic [4:0] S_SQ    = 5'd10;
    localparam logic [4:0] S_SQW   = 5'd11;
    localparam logic [4:0] S_STEP  = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_CDIV  = 5'd14;
    localparam logic [4:0] S_CWAIT = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    localparam logic [3:0] OP_N0P = 4'd0;
    localparam logic [3:0] OP_N0M = 4'd1;
    localparam logic [3:0] OP_N1P = 4'd2;
    localparam logic [3:0] OP_N1M = 4'd3;
    localparam logic [3:0] OP_N2P = 4'd4;
    localparam logic [3:0] OP_N2M = 4'd5;
    localparam logic [3:0] OP_SQ0 = 4'd6;
    localparam logic [3:0] OP_SQ1 = 4'd7;
    localparam logic [3:0] OP_SQ2 = 4'd8;
    localparam logic [3:0] OP_AC0 = 4'd9;
    localparam logic [3:0] OP_AC1 = 4'd10;
    localparam logic [3:0] OP_AC2 = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEG  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [SNW-1:0] A_LIM = SNW'(1) << (AW - 2);

    function automatic logic signed [AW-1:0] half_area(input logic signed [SNW-1:0] x);
        logic [SNW-1:0] mag;
        logic [SNW-1:0] q;
        mag = x[SNW-1] ? SNW'(-x) : SNW'(x);
        q   = (mag + 1'b1) >> 1;
        if (q > A_LIM) begin
            q = A_LIM;
        end
        return x[SNW-1] ? -$signed(q[AW-1:0]) : $signed(q[AW-1:0]);
    endfunction

    logic [4:0]              r_state;
    logic [CNTW-1:0]         r_count;
    logic                    r_ovf;
    logic                    r_tri;
    logic                    r_deg;
    logic [31:0]             r_thr;
    logic [1:0]              r_k;
    logic [ADRW-1:0]         r_i;
    logic [3:0]              r_op;
    logic signed [SW-1:0]    r_sum  [3];
    logic signed [CW-1:0]    r_m    [3];
    logic signed [CW-1:0]    r_o    [3];
    logic signed [CW-1:0]    r_p    [3];
    logic signed [CW-1:0]    r_q    [3];
    logic signed [NW-1:0]    r_n    [3];
    logic signed [SNW-1:0]   r_sn   [3];
    logic signed [SACW-1:0]  r_sac  [3];
    logic [RW-1:0]           r_mag2;
    logic [QW-1:0]           r_a;
    logic [SAW-1:0]          r_sa;
    logic signed [CW-1:0]    r_cx   [3];
    logic signed [AW-1:0]    r_ar   [3];
    logic [1:0]              r_st;

    logic                    in_acc;
    logic                    store_ok;
    logic [CNTW-1:0]         cnt_new;
    logic [CNTW-1:0]         i_next;
    logic                    i_wrap;
    logic [ADRW-1:0]         raddr;
    logic [3*CW-1:0]         rdata;
    logic signed [CW-1:0]    vin    [3];
    logic signed [CW-1:0]    rv     [3];
    logic signed [CW:0]      d_a    [3];
    logic signed [CW:0]      d_b    [3];
    logic signed [CW+1:0]    c_s    [3];
    logic signed [MW:0]      sel_x;
    logic signed [MW:0]      sel_y;
    logic [MW-1:0]           mag_x;
    logic [MW-1:0]           mag_y;
    logic                    prod_neg;
    logic                    mul_start;
    logic                    mul_done;
    logic [PW-1:0]           prod;
    logic signed [PW:0]      sprod;
    logic                    sq_start;
    logic                    sq_done;
    logic [QW-1:0]           root;
    logic                    div_start;
    logic                    div_done;
    logic [DNW-1:0]          div_num;
    logic [DDW-1:0]          div_den;
    logic [DNW-1:0]          quo;
    logic [SW-1:0]           sum_mag;
    logic [SACW-1:0]         sac_mag;
    logic [SAW+1:0]          d3;
    logic signed [CW:0]      mean_val;
    logic signed [CW-1:0]    ctr_val;

    assign o_stall     = r_state != S_LOAD;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign store_ok    = r_count < CNTW'(MAX_VERTICES);
    assign cnt_new     = store_ok ? r_count + 1'b1 : r_count;

    assign vin[0] = i_vertex_x;
    assign vin[1] = i_vertex_y;
    assign vin[2] = i_vertex_z;
    assign rv[0]  = rdata[CW-1:0];
    assign rv[1]  = rdata[2*CW-1:CW];
    assign rv[2]  = rdata[3*CW-1:2*CW];

    assign i_next = CNTW'(r_i) + 1'b1;
    assign i_wrap = i_next == r_count;

    always_comb begin
        unique case (r_state)
            S_RDA:   raddr = r_tri ? ADRW'(0) : r_i;
            S_RDB:   raddr = r_tri ? ADRW'(1) : (i_wrap ? ADRW'(0) : i_next[ADRW-1:0]);
            S_RDC:   raddr = ADRW'(2);
            default: raddr = ADRW'(0);
        endcase
    end

    fcc_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && store_ok),
        .i_waddr (r_count[ADRW-1:0]),
        .i_wdata ({i_vertex_z, i_vertex_y, i_vertex_x}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_a[k] = (CW+1)'(r_p[k]) - (CW+1)'(r_o[k]);
            d_b[k] = (CW+1)'(r_q[k]) - (CW+1)'(r_o[k]);
            c_s[k] = (CW+2)'(r_o[k]) + (CW+2)'(r_p[k]) + (CW+2)'(r_m[k]);
        end
    end

    // operand pair for each step of one triangle
    always_comb begin
        unique case (r_op)
            OP_N0P:  begin sel_x = (MW+1)'(d_a[1]); sel_y = (MW+1)'(d_b[2]); end
            OP_N0M:  begin sel_x = (MW+1)'(d_a[2]); sel_y = (MW+1)'(d_b[1]); end
            OP_N1P:  begin sel_x = (MW+1)'(d_a[2]); sel_y = (MW+1)'(d_b[0]); end
            OP_N1M:  begin sel_x = (MW+1)'(d_a[0]); sel_y = (MW+1)'(d_b[2]); end
            OP_N2P:  begin sel_x = (MW+1)'(d_a[0]); sel_y = (MW+1)'(d_b[1]); end
            OP_N2M:  begin sel_x = (MW+1)'(d_a[1]); sel_y = (MW+1)'(d_b[0]); end
            OP_SQ0:  begin sel_x = (MW+1)'(r_n[0]); sel_y = (MW+1)'(r_n[0]); end
            OP_SQ1:  begin sel_x = (MW+1)'(r_n[1]); sel_y = (MW+1)'(r_n[1]); end
            OP_SQ2:  begin sel_x = (MW+1)'(r_n[2]); sel_y = (MW+1)'(r_n[2]); end
            OP_AC0:  begin sel_x = $signed({2'b00, r_a}); sel_y = (MW+1)'(c_s[0]); end
            OP_AC1:  begin sel_x = $signed({2'b00, r_a}); sel_y = (MW+1)'(c_s[1]); end
            default: begin sel_x = $signed({2'b00, r_a}); sel_y = (MW+1)'(c_s[2]); end
        endcase
    end

    assign mag_x    = sel_x[MW] ? MW'(-sel_x) : MW'(sel_x);
    assign mag_y    = sel_y[MW] ? MW'(-sel_y) : MW'(sel_y);
    assign prod_neg = sel_x[MW] ^ sel_y[MW];
    assign sprod    = prod_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

    assign mul_start = r_state == S_MUL;
    assign sq_start  = r_state == S_SQ;
    assign div_start = (r_state == S_MDIV) || (r_state == S_CDIV);

    fcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mag_x),
        .i_b     (mag_y),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    fcc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_mag2),
        .o_done  (sq_done),
        .o_root  (root)
    );

    // rounded division: (2|x| + d) / (2d)
    assign sum_mag = r_sum[r_k][SW-1] ? SW'(-r_sum[r_k]) : SW'(r_sum[r_k]);
    assign sac_mag = r_sac[r_k][SACW-1] ? SACW'(-r_sac[r_k]) : SACW'(r_sac[r_k]);
    assign d3      = (SAW+2)'(r_sa) + (SAW+2)'({r_sa, 1'b0});

    always_comb begin
        if (r_state == S_CDIV) begin
            div_num = (DNW'(sac_mag) << 1) + DNW'(d3);
            div_den = DDW'({d3, 1'b0});
        end else begin
            div_num = (DNW'(sum_mag) << 1) + DNW'(r_count);
            div_den = DDW'({r_count, 1'b0});
        end
    end

    fcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign mean_val = r_sum[r_k][SW-1] ? -$signed({1'b0, quo[CW-1:0]})
                                       : $signed({1'b0, quo[CW-1:0]});

    always_comb begin
        if (r_sac[r_k][SACW-1]) begin
            ctr_val = (quo > DNW'(2 ** (CW - 1))) ? C_MIN : CW'(-$signed({1'b0, quo[CW-1:0]}));
        end else begin
            ctr_val = (quo > DNW'(C_MAX)) ? C_MAX : $signed(quo[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_thr   <= THR_RESET;
            r_k     <= '0;
            r_op    <= OP_N0P;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (store_ok) begin
                            r_count <= cnt_new;
                            for (int k = 0; k < 3; k++) begin
                                r_sum[k] <= r_sum[k] + SW'(vin[k]);
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_vertex) begin
                            r_tri <= cnt_new == CNTW'(3);
                            r_k   <= '0;
                            r_i   <= '0;
                            r_sa  <= '0;
                            for (int k = 0; k < 3; k++) begin
                                r_sn[k]  <= '0;
                                r_sac[k] <= '0;
                            end
                            if (cnt_new == '0) begin
                                // empty face
                                for (int k = 0; k < 3; k++) begin
                                    r_cx[k] <= '0;
                                    r_ar[k] <= '0;
                                end
                                r_st    <= (r_ovf || !store_ok) ? ST_DROP : ST_DEG;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_MDIV;
                            end
                        end
                    end
                end
                S_MDIV: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (div_done) begin
                        r_m[r_k] <= mean_val[CW-1:0];
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_RDA;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MDIV;
                        end
                    end
                end
                S_RDA: begin
                    r_op    <= OP_N0P;
                    r_mag2  <= '0;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_o     <= rv;
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_p     <= rv;
                    r_q     <= r_m;
                    r_state <= r_tri ? S_RDD : S_MUL;
                end
                S_RDD: begin
                    r_q     <= rv;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_MULW;
                S_MULW: begin
                    if (mul_done) begin
                        unique case (r_op)
                            OP_N0P: r_n[0] <= sprod[NW-1:0];
                            OP_N0M: r_n[0] <= r_n[0] - sprod[NW-1:0];
                            OP_N1P: r_n[1] <= sprod[NW-1:0];
                            OP_N1M: r_n[1] <= r_n[1] - sprod[NW-1:0];
                            OP_N2P: r_n[2] <= sprod[NW-1:0];
                            OP_N2M: r_n[2] <= r_n[2] - sprod[NW-1:0];
                            OP_SQ0, OP_SQ1, OP_SQ2: r_mag2 <= r_mag2 + prod[RW-1:0];
                            OP_AC0: r_sac[0] <= r_sac[0] + sprod[SACW-1:0];
                            OP_AC1: r_sac[1] <= r_sac[1] + sprod[SACW-1:0];
                            default: r_sac[2] <= r_sac[2] + sprod[SACW-1:0];
                        endcase
                        r_op <= r_op + 1'b1;
                        priority if (r_op == OP_N2M && r_tri) begin
                            r_state <= S_TFIN;
                        end else if (r_op == OP_SQ2) begin
                            r_state <= S_SQ;
                        end else if (r_op == OP_AC2) begin
                            r_state <= S_STEP;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_TFIN: begin
                    for (int k = 0; k < 3; k++) begin
                        r_cx[k] <= r_m[k];
                        r_ar[k] <= half_area(SNW'(r_n[k]));
                    end
                    r_st    <= r_ovf ? ST_DROP : ST_OK;
                    r_state <= S_OUT;
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: begin
                    if (sq_done) begin
                        r_a  <= root;
                        r_sa <= r_sa + SAW'(root);
                        for (int k = 0; k < 3; k++) begin
                            r_sn[k] <= r_sn[k] + SNW'(r_n[k]);
                        end
                        r_state <= S_MUL;
                    end
                end
                S_STEP: begin
                    if (i_wrap) begin
                        r_state <= S_FIN;
                    end else begin
                        r_i     <= i_next[ADRW-1:0];
                        r_state <= S_RDA;
                    end
                end
                S_FIN: begin
                    r_k <= '0;
                    if (r_sa == '0 || r_sa < SAW'(r_thr)) begin
                        for (int k = 0; k < 3; k++) begin
                            r_cx[k] <= r_m[k];
                            r_ar[k] <= '0;
                        end
                        r_st    <= r_ovf ? ST_DROP : ST_DEG;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (div_done) begin
                        r_cx[r_k] <= ctr_val;
                        if (r_k == 2'd2) begin
                            for (int k = 0; k < 3; k++) begin
                                r_ar[k] <= half_area(r_sn[k]);
                            end
                            r_st    <= r_ovf ? ST_DROP : ST_OK;
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_CDIV;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        // drop the finished face
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            r_sum[k] <= '0;
                        end
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign r_deg = r_st == ST_DEG;

    assign o_valid       = r_state == S_OUT;
    assign o_centre_x    = r_cx[0];
    assign o_centre_y    = r_cx[1];
    assign o_centre_z    = r_cx[2];
    assign o_area_x      = r_ar[0];
    assign o_area_y      = r_ar[1];
    assign o_area_z      = r_ar[2];
    assign o_face_status = r_st;

`ifndef SYNTHESIS
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while accepting vertices");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_face_status != 2'd3))
        else $error("invalid face status");
    a_degen_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_deg) |-> (o_area_x == '0 && o_area_y == '0 && o_area_z == '0))
        else $error("degenerate face with nonzero area");
`endif

endmodule

/* hdl/fcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fcc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_mul
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module fcc_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [fcc_pkg::MW-1:0]  i_a,
    input  logic [fcc_pkg::MW-1:0]  i_b,
    output logic                    o_done,
    output logic [fcc_pkg::PW-1:0]  o_prod
);
    import fcc_pkg::*;

    localparam int CNTW = $clog2(MW);

    logic [PW-1:0]   r_acc;
    logic [PW-1:0]   r_mc;
    logic [MW-1:0]   r_mp;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_mc   <= PW'(i_a);
                r_mp   <= i_b;
                r_cnt  <= CNTW'(MW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc <= r_mc << 1;
                r_mp <= r_mp >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hdl/fcc_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module fcc_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [fcc_pkg::RW-1:0]  i_rad,
    output logic                    o_done,
    output logic [fcc_pkg::QW-1:0]  o_root
);
    import fcc_pkg::*;

    localparam int CNTW = $clog2(QW);

    logic [RW-1:0]   r_rad;
    logic [QW:0]     r_rem;
    logic [QW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [QW+2:0]   rem2;
    logic [QW+2:0]   trial;
    logic            fits;

    assign rem2  = {r_rem, r_rad[RW-1:RW-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(QW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= fits ? (QW+1)'(rem2 - trial) : rem2[QW:0];
                r_root <= {r_root[QW-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/fcc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcc_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [fcc_pkg::DNW-1:0] i_num,
    input  logic [fcc_pkg::DDW-1:0] i_den,
    output logic                    o_done,
    output logic [fcc_pkg::DNW-1:0] o_quo
);
    import fcc_pkg::*;

    localparam int CNTW = $clog2(DNW);

    logic [DNW-1:0]  r_num;
    logic [DDW-1:0]  r_den;
    logic [DDW-1:0]  r_rem;
    logic [DNW-1:0]  r_quo;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DDW:0]    rem2;
    logic            fits;

    assign rem2 = {r_rem, r_num[DNW-1]};
    assign fits = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= CNTW'(DNW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= fits ? DDW'(rem2 - {1'b0, r_den}) : rem2[DDW-1:0];
                r_quo <= {r_quo[DNW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polygon_face_centre_and_area. Faces of random size
// and shape are streamed in; a scoreboard predicts each face centre, area
// vector and status and compares them with every result that comes out.
// Both channels idle at random, and the threshold moves between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam longint    C_MAX     = 64'sd8388607;
    localparam longint    C_MIN     = -64'sd8388608;
    localparam longint    A_LIM     = 64'sd2251799813685248;
    localparam int        MAXV      = fcc_pkg::MAX_VERT_DEF;
    localparam int        CW        = fcc_pkg::CW;
    localparam int        AW        = fcc_pkg::AW;
    localparam longint    LIMIT     = 64'd20000000;
    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_DEGEN   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef longint t_vec3[3];

    typedef struct {
        logic signed [fcc_pkg::CW-1:0] centre[3];
        logic signed [fcc_pkg::AW-1:0] area[3];
        logic [1:0]                    status;
    } t_face_result;

    class face_scoreboard;
        longint         verts[MAXV][3];
        int             count;
        bit             dropped;
        longint unsigned threshold;
        t_face_result   faces_due[$];
        int             errors;

        function new();
            count = 0;
            dropped = 0;
            threshold = 1;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function int pending();
            return faces_due.size();
        endfunction

        // nearest, ties away from zero
        function longint round_div(longint x, longint d);
            longint m, q;
            m = x < 0 ? -x : x;
            q = (2 * m + d) / (2 * d);
            return x < 0 ? -q : q;
        endfunction

        function longint halve_area(longint x);
            longint q;
            q = ((x < 0 ? -x : x) + 1) >>> 1;
            if (q > A_LIM)
                q = A_LIM;
            return x < 0 ? -q : q;
        endfunction

        function t_vec3 cross_edges(t_vec3 o, t_vec3 p, t_vec3 q);
            t_vec3 a, b, n;
            for (int k = 0; k < 3; k++) begin
                a[k] = p[k] - o[k];
                b[k] = q[k] - o[k];
            end
            n[0] = a[1] * b[2] - a[2] * b[1];
            n[1] = a[2] * b[0] - a[0] * b[2];
            n[2] = a[0] * b[1] - a[1] * b[0];
            return n;
        endfunction

        function longint weighted_centre(logic signed [127:0] num, longint unsigned d);
            logic [127:0] mag, q, wd;
            mag = num < 0 ? -num : num;
            wd = d;
            q = (2 * mag + wd) / (2 * wd);
            if (num < 0)
                return (q > 128'd8388608) ? C_MIN : -longint'(q);
            return (q > 128'd8388607) ? C_MAX : longint'(q);
        endfunction

        function longint unsigned floor_root(logic [127:0] x);
            logic [127:0] r, t;
            r = 0;
            for (int b = 52; b >= 0; b--) begin
                t = r | (128'd1 << b);
                if (t * t <= x)
                    r = t;
            end
            return longint'(r);
        endfunction

        function void note_vertex(longint vx, longint vy, longint vz, bit last);
            t_face_result       r;
            t_vec3              m, sn, nv, p, q, v0, v1, v2;
            logic signed [127:0] sac[3], wa, wc, w;
            logic [127:0]       mag2;
            longint unsigned    sa, a;
            longint             c, s;
            bit                 degen;
            int                 n;

            if (count < MAXV) begin
                verts[count][0] = vx;
                verts[count][1] = vy;
                verts[count][2] = vz;
                count++;
            end else begin
                dropped = 1;
            end
            if (!last)
                return;

            n = count;
            degen = 0;
            for (int k = 0; k < 3; k++) begin
                r.centre[k] = '0;
                r.area[k] = '0;
            end
            if (n == 3) begin
                for (int k = 0; k < 3; k++) begin
                    v0[k] = verts[0][k];
                    v1[k] = verts[1][k];
                    v2[k] = verts[2][k];
                    r.centre[k] = CW'(round_div(v0[k] + v1[k] + v2[k], 3));
                end
                nv = cross_edges(v0, v1, v2);
                for (int k = 0; k < 3; k++)
                    r.area[k] = AW'(halve_area(nv[k]));
            end else if (n == 0) begin
                degen = 1;
            end else begin
                sa = 0;
                for (int k = 0; k < 3; k++) begin
                    s = 0;
                    for (int i = 0; i < n; i++)
                        s += verts[i][k];
                    m[k] = round_div(s, n);
                    sn[k] = 0;
                    sac[k] = '0;
                end
                // fan around the vertex mean
                for (int i = 0; i < n; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        p[k] = verts[i][k];
                        q[k] = verts[(i + 1) % n][k];
                    end
                    nv = cross_edges(p, q, m);
                    mag2 = '0;
                    for (int k = 0; k < 3; k++) begin
                        w = nv[k];
                        mag2 += w * w;
                    end
                    a = floor_root(mag2);
                    sa += a;
                    wa = a;
                    for (int k = 0; k < 3; k++) begin
                        c = p[k] + q[k] + m[k];
                        wc = c;
                        sn[k] += nv[k];
                        sac[k] += wa * wc;
                    end
                end
                if (sa == 0 || sa < threshold) begin
                    degen = 1;
                    for (int k = 0; k < 3; k++)
                        r.centre[k] = CW'(m[k]);
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        r.centre[k] = CW'(weighted_centre(sac[k], 3 * sa));
                        r.area[k] = AW'(halve_area(sn[k]));
                    end
                end
            end
            r.status = dropped ? ST_DROPPED : (degen ? ST_DEGEN : ST_NORMAL);
            faces_due.push_back(r);
            count = 0;
            dropped = 0;
        endfunction

        task check_result(t_face_result got);
            t_face_result want;
            if (faces_due.size() == 0) begin
                report("result with no face outstanding");
                return;
            end
            want = faces_due.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (got.centre[k] !== want.centre[k])
                    report($sformatf("centre[%0d] got %0d want %0d",
                                     k, got.centre[k], want.centre[k]));
                if (got.area[k] !== want.area[k])
                    report($sformatf("area[%0d] got %0d want %0d",
                                     k, got.area[k], want.area[k]));
            end
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [fcc_pkg::CW-1:0] i_vertex_x;
    logic signed [fcc_pkg::CW-1:0] i_vertex_y;
    logic signed [fcc_pkg::CW-1:0] i_vertex_z;
    logic                          i_last_vertex;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [fcc_pkg::CW-1:0] o_centre_x;
    logic signed [fcc_pkg::CW-1:0] o_centre_y;
    logic signed [fcc_pkg::CW-1:0] o_centre_z;
    logic signed [fcc_pkg::AW-1:0] o_area_x;
    logic signed [fcc_pkg::AW-1:0] o_area_y;
    logic signed [fcc_pkg::AW-1:0] o_area_z;
    logic [1:0]                    o_face_status;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [31:0]                   i_cfg_data;

    face_scoreboard sb = new();
    longint         cycles = 0;
    bit             no_gaps = 0;
    int             hold_len = 0;
    int             sent = 0;

    polygon_face_centre_and_area u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_centre_x    (o_centre_x),
        .o_centre_y    (o_centre_y),
        .o_centre_z    (o_centre_z),
        .o_area_x      (o_area_x),
        .o_area_y      (o_area_y),
        .o_area_z      (o_area_z),
        .o_face_status (o_face_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 17);
    endfunction

    task send_vertex(longint vx, longint vy, longint vz, bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vertex_x <= CW'(vx);
        i_vertex_y <= CW'(vy);
        i_vertex_z <= CW'(vz);
        i_last_vertex <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_vertex(vx, vy, vz, last);
        sent++;
    endtask

    function longint pick_coord(int shape);
        case (shape)
            1:       return $signed($urandom_range(0, 2047)) - 1024;
            2:       return $signed($urandom_range(0, 6)) - 3;
            default: return longint'($signed(24'($urandom())));
        endcase
    endfunction

    task send_face(int n);
        int     shape;
        longint bx, by, bz, dx, dy, dz;
        shape = $urandom_range(0, 9);
        bx = pick_coord(1);
        by = pick_coord(1);
        bz = pick_coord(1);
        dx = pick_coord(2);
        dy = pick_coord(2);
        dz = pick_coord(2);
        for (int i = 0; i < n; i++) begin
            case (shape)
                8:       send_vertex(bx + i * dx, by + i * dy, bz + i * dz, i == n - 1);
                9:       send_vertex(bx, by, bz, i == n - 1);
                4, 5:    send_vertex(pick_coord(1), pick_coord(1), pick_coord(1), i == n - 1);
                6, 7:    send_vertex(pick_coord(2), pick_coord(2), pick_coord(2), i == n - 1);
                default: send_vertex(pick_coord(0), pick_coord(0), pick_coord(0), i == n - 1);
            endcase
        end
    endtask

    task drain();
        // drop valid first so the last vertex is not offered again
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task write_threshold(logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.threshold = value;
        i_cfg_valid <= 1'b0;
    endtask

    task random_faces(int target);
        int r, n, stop_at;
        stop_at = sent + target;
        while (sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                n = $urandom_range(1, 2);
            else if (r < 70)
                n = $urandom_range(3, 5);
            else if (r < 92)
                n = $urandom_range(6, 10);
            else
                n = $urandom_range(14, 19);
            if ($urandom_range(0, 15) == 0)
                no_gaps = !no_gaps;
            send_face(n);
            // pause the sender until the block has drained
            if ($urandom_range(0, 30) == 0)
                drain();
        end
        no_gaps = 0;
    endtask

    // result side: random stall, with an occasional long hold requested
    initial begin
        int           gap;
        t_face_result got;
        @(posedge i_rst_n);
        forever begin
            gap = hold_len > 0 ? hold_len : draw_gap();
            hold_len = 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got.centre[0] = o_centre_x;
            got.centre[1] = o_centre_y;
            got.centre[2] = o_centre_z;
            got.area[0] = o_area_x;
            got.area[1] = o_area_y;
            got.area[2] = o_area_z;
            got.status = o_face_status;
            sb.check_result(got);
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_vertex_x <= '0;
        i_vertex_y <= '0;
        i_vertex_z <= '0;
        i_last_vertex <= 1'b0;
        i_stall <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // triangle at the coordinate extremes
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 0, 1'b1);
        // triangle whose mean rounds away from zero
        send_vertex(-1, 2, 0, 1'b0);
        send_vertex(0, 0, -1, 1'b0);
        send_vertex(0, 0, 0, 1'b1);
        // one and two vertex faces
        send_vertex(C_MIN, 5, C_MAX, 1'b1);
        send_vertex(100, -100, 7, 1'b0);
        send_vertex(-300, 50, 9, 1'b1);
        // square, fanned around its centre
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(4096, 0, 0, 1'b0);
        send_vertex(4096, 4096, 0, 1'b0);
        send_vertex(0, 4096, 0, 1'b1);
        // coincident points give no area
        repeat (3) send_vertex(-77, 12, 3, 1'b0);
        send_vertex(-77, 12, 3, 1'b1);

        write_threshold(32'd0);
        random_faces(200);
        // hold the result side so the block backs up onto its input
        hold_len = 4000;
        random_faces(60);

        write_threshold(32'hFFFF_FFFF);
        random_faces(200);
        write_threshold($urandom_range(1, 32'h0010_0000));
        random_faces(250);
        write_threshold($urandom());
        random_faces(250);

        drain();
        repeat (100) @(posedge i_clk);
        while (sb.pending() != 0) begin
            void'(sb.faces_due.pop_front());
            sb.report("face result never delivered");
        end
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
hdl/fcc_pkg.sv
hdl/fcc_ram.sv
hdl/fcc_mul.sv
hdl/fcc_sqrt.sv
hdl/fcc_div.sv
hdl/polygon_face_centre_and_area.sv
tb/sv/testbench.sv
